@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Implication checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ src/woi_pkg.sv @@
`timescale 1ns / 1ps

package woi_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int IterW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [24:0] AngK = 25'd21361415;

  localparam int CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] RegWheelRadius = 4'd0;
  localparam logic [CfgIdxW-1:0] RegInvSep = 4'd1;

  localparam logic [3:0] OpNone = 4'd0;
  localparam logic [3:0] OpV = 4'd1;
  localparam logic [3:0] OpW1 = 4'd2;
  localparam logic [3:0] OpW = 4'd3;
  localparam logic [3:0] OpDlin = 4'd4;
  localparam logic [3:0] OpDang = 4'd5;
  localparam logic [3:0] OpTl = 4'd6;
  localparam logic [3:0] OpTh = 4'd7;
  localparam logic [3:0] OpHl = 4'd8;
  localparam logic [3:0] OpHh = 4'd9;
  localparam logic [3:0] OpPx = 4'd10;
  localparam logic [3:0] OpPy = 4'd11;

  typedef struct packed {
    logic       capture;
    logic [3:0] op;
    logic       cord_start;
    logic       load_out;
  } woi_cmd_t;

  typedef struct packed {
    logic cord_busy;
  } woi_status_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;
      5'd1: r = 32'h12E4051D;
      5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;
      5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;
      5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic [33:0] v);
    logic [31:0] r;
    if (&v[33:31] || ~|v[33:31]) r = v[31:0];
    else if (v[33]) r = 32'h80000000;
    else r = 32'h7FFFFFFF;
    return r;
  endfunction

  function automatic logic [23:0] sat24(input logic [34:0] v);
    logic [23:0] r;
    if (&v[34:23] || ~|v[34:23]) r = v[23:0];
    else if (v[34]) r = 24'h800000;
    else r = 24'h7FFFFF;
    return r;
  endfunction

  function automatic logic [15:0] sat16(input logic [18:0] v);
    logic [15:0] r;
    if (&v[18:15] || ~|v[18:15]) r = v[15:0];
    else if (v[18]) r = 16'h8000;
    else r = 16'h7FFF;
    return r;
  endfunction

endpackage

@@ src/woi_cordic.sv @@
`timescale 1ns / 1ps

module woi_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic signed [32:0] cos_o,
  output logic signed [32:0] sin_o
);

  logic signed [33:0] x_r, y_r, z_r;
  logic [woi_pkg::IterW-1:0] iter_r;
  logic busy_r, flip_r;
  logic [31:0] ang_off, ang_rot;
  logic flip;
  logic signed [33:0] sx, sy, at, neg_x, neg_y;

  assign ang_off = angle + 32'h40000000;
  assign flip = ang_off[31];
  assign ang_rot = flip ? angle + 32'h80000000 : angle;
  assign sx = x_r >>> iter_r;
  assign sy = y_r >>> iter_r;
  assign at = $signed({2'b00, woi_pkg::atan_bam(5'(iter_r))});
  assign neg_x = -x_r;
  assign neg_y = -y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      iter_r <= '0;
      flip_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      iter_r <= '0;
      flip_r <= flip;
      x_r <= woi_pkg::CordicGain;
      y_r <= '0;
      z_r <= $signed({{2{ang_rot[31]}}, ang_rot});
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_r <= x_r - sy;
        y_r <= y_r + sx;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + sy;
        y_r <= y_r - sx;
        z_r <= z_r + at;
      end
      if (iter_r == woi_pkg::IterW'(woi_pkg::CORDIC_STEPS - 1)) busy_r <= 1'b0;
      else iter_r <= iter_r + 1'b1;
    end
  end

  assign busy = busy_r;
  assign cos_o = flip_r ? neg_x[32:0] : x_r[32:0];
  assign sin_o = flip_r ? neg_y[32:0] : y_r[32:0];

endmodule

@@ src/woi_datapath.sv @@
`timescale 1ns / 1ps

module woi_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  woi_pkg::woi_cmd_t           cmd,
  output woi_pkg::woi_status_t        status,
  input  logic                        in_command,
  input  logic signed [23:0]          in_vel_back_left,
  input  logic signed [23:0]          in_vel_back_right,
  input  logic signed [23:0]          in_vel_front_left,
  input  logic signed [23:0]          in_vel_front_right,
  input  logic [23:0]                 in_step_time,
  input  logic                        cfg_write,
  input  logic [woi_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [23:0]                 cfg_data,
  output logic signed [31:0]          out_pos_x,
  output logic signed [31:0]          out_pos_y,
  output logic [31:0]                 out_heading,
  output logic signed [15:0]          out_quat_z,
  output logic signed [15:0]          out_quat_w,
  output logic signed [23:0]          out_lin_velocity,
  output logic signed [23:0]          out_ang_velocity
);

  logic [15:0] radius_r;
  logic [23:0] inv_sep_r;
  logic [23:0] left_r, right_r, dt_r;
  logic [24:0] v_r;
  logic [25:0] w1_r;
  logic [34:0] w_r;
  logic [33:0] dlin_r;
  logic [59:0] dang_r;
  logic [54:0] p1_r;
  logic [31:0] turn_r, half_r;
  logic [31:0] pos_x_r, pos_y_r, heading_r;
  logic [31:0] o_x_r, o_y_r, o_h_r;
  logic [15:0] o_qz_r, o_qw_r;
  logic [23:0] o_lin_r, o_ang_r;

  logic [24:0] sum_l, sum_r, lsum, ldiff;
  logic [59:0] hd;
  logic signed [35:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [68:0] prod;
  logic [63:0] acc;
  logic [33:0] pos_x_sum, pos_y_sum, qz_sum, qw_sum;
  logic [31:0] mid, ang_b;
  logic busy_a, busy_b;
  logic signed [32:0] cos_a, sin_a, cos_b, sin_b;

  assign sum_l = {in_vel_back_left[23], in_vel_back_left}
               + {in_vel_front_left[23], in_vel_front_left};
  assign sum_r = {in_vel_back_right[23], in_vel_back_right}
               + {in_vel_front_right[23], in_vel_front_right};
  assign lsum = {left_r[23], left_r} + {right_r[23], right_r};
  assign ldiff = {right_r[23], right_r} - {left_r[23], left_r};
  assign hd = {dang_r[59], dang_r[59:1]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      woi_pkg::OpV: begin
        mul_a = $signed({20'b0, radius_r});
        mul_b = $signed({{8{lsum[24]}}, lsum});
      end
      woi_pkg::OpW1: begin
        mul_a = $signed({20'b0, radius_r});
        mul_b = $signed({{8{ldiff[24]}}, ldiff});
      end
      woi_pkg::OpW: begin
        mul_a = $signed({{10{w1_r[25]}}, w1_r});
        mul_b = $signed({9'b0, inv_sep_r});
      end
      woi_pkg::OpDlin: begin
        mul_a = $signed({{11{v_r[24]}}, v_r});
        mul_b = $signed({9'b0, dt_r});
      end
      woi_pkg::OpDang: begin
        mul_a = $signed({w_r[34], w_r});
        mul_b = $signed({9'b0, dt_r});
      end
      woi_pkg::OpTl: begin
        mul_a = $signed({6'b0, dang_r[29:0]});
        mul_b = $signed({8'b0, woi_pkg::AngK});
      end
      woi_pkg::OpTh: begin
        mul_a = $signed({{6{dang_r[59]}}, dang_r[59:30]});
        mul_b = $signed({8'b0, woi_pkg::AngK});
      end
      woi_pkg::OpHl: begin
        mul_a = $signed({6'b0, hd[29:0]});
        mul_b = $signed({8'b0, woi_pkg::AngK});
      end
      woi_pkg::OpHh: begin
        mul_a = $signed({{6{hd[59]}}, hd[59:30]});
        mul_b = $signed({8'b0, woi_pkg::AngK});
      end
      woi_pkg::OpPx: begin
        mul_a = $signed({{2{dlin_r[33]}}, dlin_r});
        mul_b = cos_a;
      end
      woi_pkg::OpPy: begin
        mul_a = $signed({{2{dlin_r[33]}}, dlin_r});
        mul_b = sin_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign acc = {9'b0, p1_r} + {prod[33:0], 30'b0};
  assign pos_x_sum = {{2{pos_x_r[31]}}, pos_x_r} + {prod[66], prod[66:34]};
  assign pos_y_sum = {{2{pos_y_r[31]}}, pos_y_r} + {prod[66], prod[66:34]};
  assign qz_sum = {sin_b[32], sin_b} + 34'd16384;
  assign qw_sum = {cos_b[32], cos_b} + 34'd16384;
  assign mid = heading_r + half_r;
  assign ang_b = heading_r + turn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd3277;
      inv_sep_r <= 24'd327680;
    end else if (cfg_write) begin
      case (cfg_index)
        woi_pkg::RegWheelRadius: radius_r <= cfg_data[15:0];
        woi_pkg::RegInvSep: inv_sep_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      heading_r <= '0;
    end else if (cmd.capture && in_command) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      heading_r <= '0;
    end else if (cmd.op == woi_pkg::OpPx) begin
      pos_x_r <= woi_pkg::sat32(pos_x_sum);
    end else if (cmd.op == woi_pkg::OpPy) begin
      pos_y_r <= woi_pkg::sat32(pos_y_sum);
      heading_r <= heading_r + turn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      left_r <= sum_l[24:1];
      right_r <= sum_r[24:1];
      dt_r <= in_step_time;
      if (in_command) begin
        turn_r <= '0;
        v_r <= '0;
        w_r <= '0;
      end
    end else begin
      case (cmd.op)
        woi_pkg::OpV: v_r <= prod[41:17];
        woi_pkg::OpW1: w1_r <= prod[41:16];
        woi_pkg::OpW: w_r <= prod[50:16];
        woi_pkg::OpDlin: dlin_r <= prod[49:16];
        woi_pkg::OpDang: dang_r <= prod[59:0];
        woi_pkg::OpTl: p1_r <= prod[54:0];
        woi_pkg::OpTh: turn_r <= acc[63:32];
        woi_pkg::OpHl: p1_r <= prod[54:0];
        woi_pkg::OpHh: half_r <= acc[63:32];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_x_r <= pos_x_r;
      o_y_r <= pos_y_r;
      o_h_r <= heading_r;
      o_qz_r <= woi_pkg::sat16(qz_sum[33:15]);
      o_qw_r <= woi_pkg::sat16(qw_sum[33:15]);
      o_lin_r <= woi_pkg::sat24({{10{v_r[24]}}, v_r});
      o_ang_r <= woi_pkg::sat24(w_r);
    end
  end

  woi_cordic u_cordic_mid (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cord_start),
    .angle ({mid[30:0], 1'b0}),
    .busy  (busy_a),
    .cos_o (cos_a),
    .sin_o (sin_a)
  );

  woi_cordic u_cordic_head (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.cord_start),
    .angle (ang_b),
    .busy  (busy_b),
    .cos_o (cos_b),
    .sin_o (sin_b)
  );

  assign status.cord_busy = busy_a | busy_b;

  assign out_pos_x = $signed(o_x_r);
  assign out_pos_y = $signed(o_y_r);
  assign out_heading = o_h_r;
  assign out_quat_z = $signed(o_qz_r);
  assign out_quat_w = $signed(o_qw_r);
  assign out_lin_velocity = $signed(o_lin_r);
  assign out_ang_velocity = $signed(o_ang_r);

endmodule

@@ src/woi_ctrl.sv @@
`timescale 1ns / 1ps

module woi_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_command,
  output logic                 out_valid,
  input  logic                 out_ready,
  output woi_pkg::woi_cmd_t    cmd,
  input  woi_pkg::woi_status_t status
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_V = 4'd1;
  localparam logic [3:0] S_W1 = 4'd2;
  localparam logic [3:0] S_W = 4'd3;
  localparam logic [3:0] S_DLIN = 4'd4;
  localparam logic [3:0] S_DANG = 4'd5;
  localparam logic [3:0] S_TL = 4'd6;
  localparam logic [3:0] S_TH = 4'd7;
  localparam logic [3:0] S_HL = 4'd8;
  localparam logic [3:0] S_HH = 4'd9;
  localparam logic [3:0] S_CSTART = 4'd10;
  localparam logic [3:0] S_CWAIT = 4'd11;
  localparam logic [3:0] S_PX = 4'd12;
  localparam logic [3:0] S_PY = 4'd13;
  localparam logic [3:0] S_FIN = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic zero_cmd_r, zero_cmd_nxt;
  logic accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    zero_cmd_nxt = zero_cmd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.capture = accept;
    cmd.op = woi_pkg::OpNone;
    cmd.cord_start = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          zero_cmd_nxt = in_command;
          state_nxt = in_command ? S_CSTART : S_V;
        end
      end
      S_V: begin
        cmd.op = woi_pkg::OpV;
        state_nxt = S_W1;
      end
      S_W1: begin
        cmd.op = woi_pkg::OpW1;
        state_nxt = S_W;
      end
      S_W: begin
        cmd.op = woi_pkg::OpW;
        state_nxt = S_DLIN;
      end
      S_DLIN: begin
        cmd.op = woi_pkg::OpDlin;
        state_nxt = S_DANG;
      end
      S_DANG: begin
        cmd.op = woi_pkg::OpDang;
        state_nxt = S_TL;
      end
      S_TL: begin
        cmd.op = woi_pkg::OpTl;
        state_nxt = S_TH;
      end
      S_TH: begin
        cmd.op = woi_pkg::OpTh;
        state_nxt = S_HL;
      end
      S_HL: begin
        cmd.op = woi_pkg::OpHl;
        state_nxt = S_HH;
      end
      S_HH: begin
        cmd.op = woi_pkg::OpHh;
        state_nxt = S_CSTART;
      end
      S_CSTART: begin
        cmd.cord_start = 1'b1;
        state_nxt = S_CWAIT;
      end
      S_CWAIT: begin
        if (!status.cord_busy) state_nxt = zero_cmd_r ? S_FIN : S_PX;
      end
      S_PX: begin
        cmd.op = woi_pkg::OpPx;
        state_nxt = S_PY;
      end
      S_PY: begin
        cmd.op = woi_pkg::OpPy;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      zero_cmd_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      zero_cmd_r <= zero_cmd_nxt;
    end
  end

endmodule

@@ src/wheel_odometry_integrator.sv @@
`timescale 1ns / 1ps

// Integrates a differential-drive pose from four wheel speeds and a step time, one
// transaction at a time. An update runs from acceptance to a valid result in this order:
// nine passes through the single shared multiplier, a start of the two CORDIC
// rotators that run side by side, a wait while they do their 16 iterations, two more
// multiplier passes for the position and a load of the result register.
// A pose reset command skips the multiplier passes: it only runs the rotators and loads
// the result. The input is ready again in the cycle after the result is loaded, so an
// update is accepted only after the previous one has loaded its result. The result
// register lets a new transaction enter while the previous result waits; that
// transaction then stalls before its own result load until the waiting result is taken.
// Configuration writes are always ready and must only occur while the block is idle.
module wheel_odometry_integrator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic signed [23:0]          in_vel_back_left,
  input  logic signed [23:0]          in_vel_back_right,
  input  logic signed [23:0]          in_vel_front_left,
  input  logic signed [23:0]          in_vel_front_right,
  input  logic [23:0]                 in_step_time,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_pos_x,
  output logic signed [31:0]          out_pos_y,
  output logic [31:0]                 out_heading,
  output logic signed [15:0]          out_quat_z,
  output logic signed [15:0]          out_quat_w,
  output logic signed [23:0]          out_lin_velocity,
  output logic signed [23:0]          out_ang_velocity,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [woi_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [23:0]                 cfg_data
);

  woi_pkg::woi_cmd_t cmd;
  woi_pkg::woi_status_t status;

  assign cfg_ready = 1'b1;

  woi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .status     (status)
  );

  woi_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_command         (in_command),
    .in_vel_back_left   (in_vel_back_left),
    .in_vel_back_right  (in_vel_back_right),
    .in_vel_front_left  (in_vel_front_left),
    .in_vel_front_right (in_vel_front_right),
    .in_step_time       (in_step_time),
    .cfg_write          (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_pos_x          (out_pos_x),
    .out_pos_y          (out_pos_y),
    .out_heading        (out_heading),
    .out_quat_z         (out_quat_z),
    .out_quat_w         (out_quat_w),
    .out_lin_velocity   (out_lin_velocity),
    .out_ang_velocity   (out_ang_velocity)
  );

endmodule

@@ src/woi_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module woi_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // After reset the block is idle with no result pending.
  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (in_ready && !out_valid))
  // One transaction is worked on at a time.
  `ASSERT_CLK(a_one_at_a_time, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  // A pending result is not withdrawn.
  `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid)

endmodule

bind wheel_odometry_integrator woi_checker u_woi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready)
);
